@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define SFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked property that also holds during reset
`define SFD_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/sfd_pkg.sv @@
// package of types, constants and the crc step for the slip frame decoder
`default_nettype none

package sfd_pkg;

    localparam int unsigned BUFFER_BYTES_DEF = 256;

    localparam logic [7:0] END_BYTE        = 8'hC0;
    localparam logic [7:0] ESC_BYTE        = 8'hDB;
    localparam logic [7:0] ESC_END_BYTE    = 8'hDC;
    localparam logic [7:0] ESC_ESC_BYTE    = 8'hDD;
    localparam logic [7:0] HEADER_RESERVED = 8'h0E;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_DROP = 2'd1,
        ST_GOOD = 2'd2
    } status_t;

    // one byte of crc-16, msb first, no reflection
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (v[15])
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[14:0], 1'b0};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hdl/sfd_req_if.sv @@
// request channel: wire byte or payload read
`default_nettype none

interface sfd_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] wire_byte;
    logic [7:0] read_index;

    modport source (output valid, mode, wire_byte, read_index, input ready);
    modport sink   (input valid, mode, wire_byte, read_index, output ready);
endinterface

`default_nettype wire

@@ hdl/sfd_rsp_if.sv @@
// result channel: frame status and read data
`default_nettype none

interface sfd_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] frame_type;
    logic       frame_sequence;
    logic [7:0] body_length;
    logic [7:0] read_data;

    modport source (output valid, status, frame_type, frame_sequence, body_length,
                    read_data, input ready);
    modport sink   (input valid, status, frame_type, frame_sequence, body_length,
                    read_data, output ready);
endinterface

`default_nettype wire

@@ hdl/sfd_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none

module sfd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output      logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ hdl/slip_frame_decoder_crc16.sv @@
// slip deframer with crc-16 check: one request per cycle while ready is high, one result each
//
// Each request either feeds one SLIP wire byte (mode 0) or reads one payload byte of
// the last good frame (mode 1). Requests are taken one per clock while ready is high; a
// result passes the registered read of the frame memory and then the output register.
// Ready falls only while both the memory read stage and the output register hold results
// and the result side stalls. Unescaped bytes go into a BUFFER_BYTES x 8 synchronous
// memory at the fill position; the header byte is kept in a register as well so the
// check at the delimiter needs no memory read. The crc runs one byte per stored byte
// with a two byte delay so the trailing check bytes stay out. The memory is not cleared
// after reset: a payload read only reaches entries written by a good frame, and reads at
// or past the good frame's length return 0. Reads see whatever the memory now holds, so
// a later frame in progress may overwrite them.
`default_nettype none

module slip_frame_decoder_crc16 #(
    parameter int unsigned BUFFER_BYTES = sfd_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sfd_req_if.sink    req,
    sfd_rsp_if.source  rsp
);

    import sfd_pkg::*;

    localparam int unsigned AW = $clog2(BUFFER_BYTES);
    localparam int unsigned FW = $clog2(BUFFER_BYTES + 1);

    // frame state
    logic [FW-1:0] fill_reg,   fill_next;
    logic          esc_reg,    esc_next;
    logic          disc_reg,   disc_next;
    logic [15:0]   crc_reg,    crc_next;
    logic [15:0]   held_reg,   held_next;
    logic [FW-1:0] good_reg,   good_next;
    logic [7:0]    hdr_reg,    hdr_next;

    // memory read stage
    logic          p1_valid_reg;
    logic [1:0]    p1_status_reg;
    logic [3:0]    p1_type_reg;
    logic          p1_seq_reg;
    logic [7:0]    p1_len_reg;
    logic          p1_rdok_reg;

    // output register
    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [3:0]    out_type_reg;
    logic          out_seq_reg;
    logic [7:0]    out_len_reg;
    logic [7:0]    out_rdata_reg;

    // handshake and per request results
    logic          accept;
    logic          advance;
    status_t       status_c;
    logic [3:0]    type_c;
    logic          seq_c;
    logic [7:0]    len_c;
    logic          rdok_c;
    logic [31:0]   rd_pos;
    logic [31:0]   plen32;
    logic [7:0]    byte_c;
    logic          keep;

    // memory port
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    // the read stage moves on when the output register is free or being taken
    assign advance   = p1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !p1_valid_reg || advance;
    assign accept    = req.valid && req.ready;

    // payload byte i sits behind the header at memory position i + 1
    assign rd_pos  = 32'(req.read_index) + 32'd1;
    assign rd_addr = rd_pos[AW-1:0];
    assign rd_en   = accept && req.mode;
    assign plen32  = 32'(fill_reg) - 32'd3;
    assign wr_addr = fill_reg[AW-1:0];

    always_comb
    begin
        fill_next = fill_reg;
        esc_next  = esc_reg;
        disc_next = disc_reg;
        crc_next  = crc_reg;
        held_next = held_reg;
        good_next = good_reg;
        hdr_next  = hdr_reg;
        status_c  = ST_NONE;
        type_c    = 4'd0;
        seq_c     = 1'b0;
        len_c     = 8'd0;
        rdok_c    = 1'b0;
        wr_en     = 1'b0;
        byte_c    = req.wire_byte;
        keep      = 1'b0;

        if (accept)
        begin
            if (req.mode)
            begin
                rdok_c = (32'(req.read_index) < 32'(good_reg))
                      && (rd_pos < 32'(BUFFER_BYTES));
            end
            else if (req.wire_byte == END_BYTE)
            begin
                if (disc_reg || esc_reg)
                begin
                    // delimiter ends a discard or cuts an escape short
                    status_c  = ST_DROP;
                    esc_next  = 1'b0;
                    disc_next = 1'b0;
                    fill_next = '0;
                    crc_next  = CRC_INIT;
                    held_next = 16'd0;
                end
                else if (fill_reg != '0)
                begin
                    fill_next = '0;
                    crc_next  = CRC_INIT;
                    held_next = 16'd0;
                    if (fill_reg < FW'(3)
                        || (hdr_reg & HEADER_RESERVED) != 8'd0
                        || hdr_reg[7:4] == 4'd0
                        || {held_reg[7:0], held_reg[15:8]} != crc_reg)
                    begin
                        status_c = ST_DROP;
                    end
                    else
                    begin
                        // good frame: header, two crc bytes, payload in between
                        status_c  = ST_GOOD;
                        type_c    = hdr_reg[7:4];
                        seq_c     = hdr_reg[0];
                        len_c     = plen32[7:0];
                        good_next = plen32[FW-1:0];
                    end
                end
            end
            else if (!disc_reg)
            begin
                keep = 1'b1;
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (req.wire_byte == ESC_END_BYTE)
                        byte_c = END_BYTE;
                    else if (req.wire_byte == ESC_ESC_BYTE)
                        byte_c = ESC_BYTE;
                    else
                    begin
                        // bad escape: drop the frame and skip to the next delimiter
                        keep      = 1'b0;
                        disc_next = 1'b1;
                        fill_next = '0;
                        crc_next  = CRC_INIT;
                        held_next = 16'd0;
                    end
                end
                else if (req.wire_byte == ESC_BYTE)
                begin
                    keep     = 1'b0;
                    esc_next = 1'b1;
                end

                if (keep)
                begin
                    if (fill_reg >= FW'(BUFFER_BYTES))
                    begin
                        // overflow
                        esc_next  = 1'b0;
                        disc_next = 1'b1;
                        fill_next = '0;
                        crc_next  = CRC_INIT;
                        held_next = 16'd0;
                    end
                    else
                    begin
                        if (fill_reg >= FW'(2))
                            crc_next = crc_step(crc_reg, held_reg[15:8]);
                        held_next = {held_reg[7:0], byte_c};
                        if (fill_reg == '0)
                            hdr_next = byte_c;
                        wr_en     = 1'b1;
                        fill_next = fill_reg + FW'(1);
                    end
                end
            end
        end
    end

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (byte_c),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            esc_reg  <= 1'b0;
            disc_reg <= 1'b0;
            crc_reg  <= CRC_INIT;
            held_reg <= 16'd0;
            good_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            esc_reg  <= esc_next;
            disc_reg <= disc_next;
            crc_reg  <= crc_next;
            held_reg <= held_next;
            good_reg <= good_next;
        end
    end

    // header byte, only looked at once a frame holds it
    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
    end

    // valid bits of the two result stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                p1_valid_reg <= 1'b1;
            else if (advance)
                p1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result payload, read data joins from the memory output
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_status_reg <= status_c;
            p1_type_reg   <= type_c;
            p1_seq_reg    <= seq_c;
            p1_len_reg    <= len_c;
            p1_rdok_reg   <= rdok_c;
        end
        if (advance)
        begin
            out_status_reg <= p1_status_reg;
            out_type_reg   <= p1_type_reg;
            out_seq_reg    <= p1_seq_reg;
            out_len_reg    <= p1_len_reg;
            out_rdata_reg  <= p1_rdok_reg ? rd_data : 8'd0;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.frame_type     = out_type_reg;
    assign rsp.frame_sequence = out_seq_reg;
    assign rsp.body_length    = out_len_reg;
    assign rsp.read_data      = out_rdata_reg;

endmodule

`default_nettype wire

@@ hdl/sfd_checker.sv @@
// port level checks for the slip frame decoder, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module sfd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] rsp_status,
    input wire logic [3:0] rsp_type,
    input wire logic       rsp_seq,
    input wire logic [7:0] rsp_len,
    input wire logic [7:0] rsp_rdata
);

    import sfd_pkg::*;

    `SFD_ASSERT_RST(a_no_result_in_reset, clk, !rst_n |-> !rsp_valid, "result during reset")

    `SFD_ASSERT(a_result_held, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_rdata), "stalled result changed")

    `SFD_ASSERT(a_fields_only_good, clk, rst_n, rsp_valid && rsp_status != ST_GOOD |-> rsp_type == 4'd0 && rsp_seq == 1'b0 && rsp_len == 8'd0, "frame fields without good frame")

    `SFD_ASSERT(a_good_type_set, clk, rst_n, rsp_valid && rsp_status == ST_GOOD |-> rsp_type != 4'd0, "good frame with zero type")

    `SFD_ASSERT(a_read_no_status, clk, rst_n, rsp_valid && rsp_status != ST_NONE |-> rsp_rdata == 8'd0, "read data on a frame report")

endmodule

bind slip_frame_decoder_crc16 sfd_checker u_sfd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_type   (rsp.frame_type),
    .rsp_seq    (rsp.frame_sequence),
    .rsp_len    (rsp.body_length),
    .rsp_rdata  (rsp.read_data)
);

`default_nettype wire
